// ----- design/assert_macros.svh -----
// shared assertion macros, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, held off while reset is asserted
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, 1'b1 |-> (expr))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

// ----- design/lfps_pkg.sv -----
package lfps_pkg;

  // field and datapath widths
  localparam int ErrW     = 9;
  localparam int DiffW    = 10;
  localparam int GainW    = 32;
  localparam int IntW     = 32;
  localparam int ProdW    = 64;
  localparam int AccW     = 50;
  localparam int LimW     = 11;
  localparam int SpdW     = 7;
  localparam int EdgeW    = 2;
  localparam int TermW    = 13;
  localparam int SumW     = 15;
  localparam int PwrW     = 8;
  localparam int FracBits = 16;

  // register port
  localparam int DataW = 32;
  localparam int AddrW = 5;
  localparam int IdxW  = 3;

  // register indexes
  localparam logic [IdxW-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [IdxW-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [IdxW-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [IdxW-1:0] REG_PID_UPPER  = 3'd3;
  localparam logic [IdxW-1:0] REG_PID_LOWER  = 3'd4;
  localparam logic [IdxW-1:0] REG_CRUISE     = 3'd5;
  localparam logic [IdxW-1:0] REG_EDGE_SIDE  = 3'd6;
  localparam logic [IdxW-1:0] REG_OFFSET     = 3'd7;

  // fixed powers on a blue marker, and the motor power limits
  localparam logic signed [PwrW-1:0] BLUE_LEFT  = 8'sd57;
  localparam logic signed [PwrW-1:0] BLUE_RIGHT = 8'sd10;
  localparam logic signed [PwrW-1:0] POWER_MAX  = 8'sd100;
  localparam logic signed [PwrW-1:0] POWER_MIN  = -8'sd100;

  // multiplier operand pair
  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } lfps_mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic          load;
    lfps_mul_sel_t mul_sel;
    logic          acc_clr;
    logic          acc_en;
    logic          term_en;
    logic          out_load;
  } lfps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } lfps_status_t;

  // configuration registers
  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic signed [LimW-1:0]  pid_upper;
    logic signed [LimW-1:0]  pid_lower;
    logic [SpdW-1:0]         cruise_pwr;
    logic signed [EdgeW-1:0] edge_side;
    logic [SpdW-1:0]         speed_offset;
  } lfps_cfg_t;

endpackage

// ----- design/line_follow_pid_steering_core.sv -----
// PID steering for a line-following two-motor drive. Each beat on the input
// carries a signed brightness error and a blue-marker flag and yields one beat
// of left and right motor power in [-100, 100]. The previous error and a
// trapezoidal error integral are kept and updated on every sample, blue or not;
// the P, I and D products are floored to integers, summed, clamped to
// [pid_lower, pid_upper] and applied with the edge_side sign around the base
// speed less the offset. On a blue marker the powers are fixed at 57 and 10.
// After acceptance an item passes through S_INT, S_DER, S_SUM, S_TERM and
// S_OUT until its result is loaded in the output register; it waits in S_OUT
// while that register is full and stalled. A new item is accepted the cycle
// after that load, not before. The sequence is set by the single 32x32
// multiplier, used once for each of the three terms, followed by
// accumulation, clamp and output stages. The result register lets the next
// item be accepted while a result waits to be taken. Registers lie at byte
// address 4*i; pready is always high; reads return the sign- or zero-extended register value.
module line_follow_pid_steering_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // sample input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [lfps_pkg::ErrW-1:0]       in_brightness_error,
  input  logic                                   in_blue_seen,
  // motor power output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lfps_pkg::PwrW-1:0]       out_left_power,
  output logic signed [lfps_pkg::PwrW-1:0]       out_right_power,
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lfps_pkg::AddrW-1:0]             paddr,
  input  logic [lfps_pkg::DataW-1:0]             pwdata,
  output logic [lfps_pkg::DataW-1:0]             prdata,
  output logic                                   pready
);

  localparam int DataW = lfps_pkg::DataW;
  localparam int LimW  = lfps_pkg::LimW;
  localparam int SpdW  = lfps_pkg::SpdW;
  localparam int EdgeW = lfps_pkg::EdgeW;
  localparam int GainW = lfps_pkg::GainW;

  lfps_pkg::lfps_cfg_t    cfg_r;
  lfps_pkg::lfps_cmd_t    cmd;
  lfps_pkg::lfps_status_t status;

  logic                         cfg_wr;
  logic [lfps_pkg::IdxW-1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[lfps_pkg::AddrW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= 32'sd65536;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.pid_upper    <= 11'sd100;
      cfg_r.pid_lower    <= -11'sd100;
      cfg_r.cruise_pwr   <= 7'd50;
      cfg_r.edge_side    <= 2'sd1;
      cfg_r.speed_offset <= 7'd13;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lfps_pkg::REG_GAIN_P:     cfg_r.gain_p       <= pwdata[GainW-1:0];
        lfps_pkg::REG_GAIN_I:     cfg_r.gain_i       <= pwdata[GainW-1:0];
        lfps_pkg::REG_GAIN_D:     cfg_r.gain_d       <= pwdata[GainW-1:0];
        lfps_pkg::REG_PID_UPPER:  cfg_r.pid_upper    <= pwdata[LimW-1:0];
        lfps_pkg::REG_PID_LOWER:  cfg_r.pid_lower    <= pwdata[LimW-1:0];
        lfps_pkg::REG_CRUISE:     cfg_r.cruise_pwr   <= pwdata[SpdW-1:0];
        lfps_pkg::REG_EDGE_SIDE:  cfg_r.edge_side    <= pwdata[EdgeW-1:0];
        lfps_pkg::REG_OFFSET:     cfg_r.speed_offset <= pwdata[SpdW-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lfps_pkg::REG_GAIN_P:     prdata = cfg_r.gain_p;
      lfps_pkg::REG_GAIN_I:     prdata = cfg_r.gain_i;
      lfps_pkg::REG_GAIN_D:     prdata = cfg_r.gain_d;
      lfps_pkg::REG_PID_UPPER:
        prdata = {{(DataW-LimW){cfg_r.pid_upper[LimW-1]}}, cfg_r.pid_upper};
      lfps_pkg::REG_PID_LOWER:
        prdata = {{(DataW-LimW){cfg_r.pid_lower[LimW-1]}}, cfg_r.pid_lower};
      lfps_pkg::REG_CRUISE:     prdata = {{(DataW-SpdW){1'b0}}, cfg_r.cruise_pwr};
      lfps_pkg::REG_EDGE_SIDE:
        prdata = {{(DataW-EdgeW){cfg_r.edge_side[EdgeW-1]}}, cfg_r.edge_side};
      lfps_pkg::REG_OFFSET:     prdata = {{(DataW-SpdW){1'b0}}, cfg_r.speed_offset};
      default:                  prdata = '0;
    endcase
  end

  lfps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg                 (cfg_r),
    .in_brightness_error (in_brightness_error),
    .in_blue_seen        (in_blue_seen),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_left_power      (out_left_power),
    .out_right_power     (out_right_power)
  );

endmodule

// ----- design/lfps_ctrl.sv -----
`include "assert_macros.svh"

module lfps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lfps_pkg::lfps_status_t status,
  output lfps_pkg::lfps_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INT  = 3'd1;
  localparam logic [2:0] S_DER  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_TERM = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // sequence: proportional, integral and derivative products, sum, clamp, result
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = lfps_pkg::MUL_P;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        cmd.mul_sel = lfps_pkg::MUL_I;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_DER;
      end
      S_DER: begin
        cmd.mul_sel = lfps_pkg::MUL_D;
        cmd.acc_en  = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_TERM;
      end
      S_TERM: begin
        cmd.term_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // input taken only between samples
  assign in_stall = (state_r != S_IDLE);

  `ASSERT_PROP(a_load_starts_seq, clk, rst_n, cmd.load |=> (state_r == S_INT))
  `ASSERT_PROP(a_out_wait_holds, clk, rst_n,
    ((state_r == S_OUT) && !status.out_free) |=> (state_r == S_OUT))
  `ASSERT_PROP(a_out_load_ends_seq, clk, rst_n, cmd.out_load |=> (state_r == S_IDLE))

endmodule

// ----- design/lfps_dp.sv -----
`include "assert_macros.svh"

module lfps_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lfps_pkg::lfps_cmd_t                    cmd,
  output lfps_pkg::lfps_status_t                 status,
  input  lfps_pkg::lfps_cfg_t                    cfg,
  input  logic signed [lfps_pkg::ErrW-1:0]       in_brightness_error,
  input  logic                                   in_blue_seen,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [lfps_pkg::PwrW-1:0]       out_left_power,
  output logic signed [lfps_pkg::PwrW-1:0]       out_right_power
);

  localparam int ErrW  = lfps_pkg::ErrW;
  localparam int IntW  = lfps_pkg::IntW;
  localparam int IsumW = IntW + 2;
  localparam int AccW  = lfps_pkg::AccW;
  localparam int ProdW = lfps_pkg::ProdW;
  localparam int QuoW  = ProdW - lfps_pkg::FracBits;
  localparam int LimW  = lfps_pkg::LimW;
  localparam int TermW = lfps_pkg::TermW;
  localparam int SumW  = lfps_pkg::SumW;
  localparam int SpdW  = lfps_pkg::SpdW;
  localparam int PwrW  = lfps_pkg::PwrW;
  localparam int DiffW = lfps_pkg::DiffW;

  localparam logic signed [IsumW-1:0] INT_HI = {3'b000, {(IntW-1){1'b1}}};
  localparam logic signed [IsumW-1:0] INT_LO = {3'b111, {(IntW-1){1'b0}}};
  localparam logic signed [SumW-1:0]  SUM_HI = SumW'(lfps_pkg::POWER_MAX);
  localparam logic signed [SumW-1:0]  SUM_LO = SumW'(lfps_pkg::POWER_MIN);

  logic signed [ErrW-1:0]  prev_r;
  logic signed [IntW-1:0]  integ_r;
  logic signed [DiffW-1:0] diff_r;
  logic                    blue_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r;
  logic signed [TermW-1:0] term_r;
  logic                    out_valid_r;
  logic signed [PwrW-1:0]  left_r;
  logic signed [PwrW-1:0]  right_r;

  logic signed [IsumW-1:0] integ_sum;
  logic signed [IntW-1:0]  integ_nxt;
  logic signed [DiffW-1:0] diff_nxt;
  logic signed [IntW-1:0]  mul_a;
  logic signed [IntW-1:0]  mul_b;
  logic signed [AccW-1:0]  quot;
  logic signed [AccW-1:0]  upper_x;
  logic signed [AccW-1:0]  lower_x;
  logic signed [LimW-1:0]  pid;
  logic signed [TermW-1:0] pid_x;
  logic signed [TermW-1:0] edge_x;
  logic signed [SumW-1:0]  term_x;
  logic signed [SumW-1:0]  base_x;
  logic signed [SumW-1:0]  offs_x;
  logic signed [SumW-1:0]  left_sum;
  logic signed [SumW-1:0]  right_sum;
  logic signed [PwrW-1:0]  left_sat;
  logic signed [PwrW-1:0]  right_sat;

  // trapezoid integral with saturation, and error difference
  always_comb begin
    integ_sum = {{2{integ_r[IntW-1]}}, integ_r}
              + {{(IsumW-ErrW){in_brightness_error[ErrW-1]}}, in_brightness_error}
              + {{(IsumW-ErrW){prev_r[ErrW-1]}}, prev_r};
    priority if (integ_sum > INT_HI) begin
      integ_nxt = INT_HI[IntW-1:0];
    end else if (integ_sum < INT_LO) begin
      integ_nxt = INT_LO[IntW-1:0];
    end else begin
      integ_nxt = integ_sum[IntW-1:0];
    end
    diff_nxt = {in_brightness_error[ErrW-1], in_brightness_error}
             - {prev_r[ErrW-1], prev_r};
  end

  // sample state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (cmd.load) begin
      prev_r  <= in_brightness_error;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r <= diff_nxt;
      blue_r <= in_blue_seen;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = cfg.gain_p;
    mul_b = {{(IntW-ErrW){in_brightness_error[ErrW-1]}}, in_brightness_error};
    unique case (cmd.mul_sel)
      lfps_pkg::MUL_P: begin
        mul_a = cfg.gain_p;
        mul_b = {{(IntW-ErrW){in_brightness_error[ErrW-1]}}, in_brightness_error};
      end
      lfps_pkg::MUL_I: begin
        mul_a = cfg.gain_i;
        mul_b = integ_r;
      end
      lfps_pkg::MUL_D: begin
        mul_a = cfg.gain_d;
        mul_b = {{(IntW-DiffW){diff_r[DiffW-1]}}, diff_r};
      end
      default: begin
        mul_a = cfg.gain_p;
        mul_b = integ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // product floored to integer, then accumulated
  assign quot = {{(AccW-QuoW){prod_r[ProdW-1]}}, prod_r[ProdW-1:lfps_pkg::FracBits]};

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= quot;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + quot;
    end
  end

  // clamp, upper limit tested first, then signed edge factor
  always_comb begin
    upper_x = {{(AccW-LimW){cfg.pid_upper[LimW-1]}}, cfg.pid_upper};
    lower_x = {{(AccW-LimW){cfg.pid_lower[LimW-1]}}, cfg.pid_lower};
    priority if (acc_r > upper_x) begin
      pid = cfg.pid_upper;
    end else if (acc_r < lower_x) begin
      pid = cfg.pid_lower;
    end else begin
      pid = acc_r[LimW-1:0];
    end
    pid_x  = {{(TermW-LimW){pid[LimW-1]}}, pid};
    edge_x = {{(TermW-lfps_pkg::EdgeW){cfg.edge_side[lfps_pkg::EdgeW-1]}}, cfg.edge_side};
  end

  always_ff @(posedge clk) begin
    if (cmd.term_en) begin
      term_r <= pid_x * edge_x;
    end
  end

  // motor powers with saturation
  always_comb begin
    term_x    = {{(SumW-TermW){term_r[TermW-1]}}, term_r};
    base_x    = {{(SumW-SpdW){1'b0}}, cfg.cruise_pwr};
    offs_x    = {{(SumW-SpdW){1'b0}}, cfg.speed_offset};
    left_sum  = base_x + term_x - offs_x;
    right_sum = base_x - term_x - offs_x;
    priority if (left_sum > SUM_HI) begin
      left_sat = lfps_pkg::POWER_MAX;
    end else if (left_sum < SUM_LO) begin
      left_sat = lfps_pkg::POWER_MIN;
    end else begin
      left_sat = left_sum[PwrW-1:0];
    end
    priority if (right_sum > SUM_HI) begin
      right_sat = lfps_pkg::POWER_MAX;
    end else if (right_sum < SUM_LO) begin
      right_sat = lfps_pkg::POWER_MIN;
    end else begin
      right_sat = right_sum[PwrW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_r  <= blue_r ? lfps_pkg::BLUE_LEFT : left_sat;
      right_r <= blue_r ? lfps_pkg::BLUE_RIGHT : right_sat;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_left_power  = left_r;
  assign out_right_power = right_r;

  `ASSERT_ALWAYS(a_left_in_range, clk, rst_n,
    !out_valid_r || ((left_r <= lfps_pkg::POWER_MAX) && (left_r >= lfps_pkg::POWER_MIN)))
  `ASSERT_ALWAYS(a_right_in_range, clk, rst_n,
    !out_valid_r || ((right_r <= lfps_pkg::POWER_MAX) && (right_r >= lfps_pkg::POWER_MIN)))
  `ASSERT_PROP(a_blue_powers, clk, rst_n,
    (cmd.out_load && blue_r) |=>
      ((left_r == lfps_pkg::BLUE_LEFT) && (right_r == lfps_pkg::BLUE_RIGHT)))

endmodule
